@@ src/pbsr_pkg.sv @@
// Shared types, constants and helpers for the box-to-screen-rectangle projector.
`default_nettype none
package pbsr_pkg;

  localparam int COORD_W    = 24;  // world coordinate, signed Q15.8
  localparam int CORNER_W   = 25;  // corner = origin + offset, signed Q16.8
  localparam int MAT_W      = 32;  // matrix entry, signed Q15.16
  localparam int PROD_W     = CORNER_W + MAT_W;  // one corner * entry product
  localparam int CLIP_W     = 59;  // clip x, y, w sums
  localparam int NORM_W     = 40;  // denominator after normalizing
  localparam int SHIFT_W    = 5;   // normalize shift, up to CLIP_W - NORM_W
  localparam int SAT_SHIFT  = 20;  // quotient at or above 2^20 saturates
  localparam int FRAC_W     = 16;  // ratio fraction bits
  localparam int DIV_BITS   = SAT_SHIFT + FRAC_W;  // quotient bits
  localparam int RATIO_W    = DIV_BITS + 1;
  localparam int TERM_W     = RATIO_W + 2;
  localparam int DIM_W      = 16;
  localparam int PIX_PROD_W = TERM_W + DIM_W + 1;
  localparam int PIX_W      = 16;
  localparam int PIX_SHIFT  = 17;

  localparam int N_REGS = 8;
  localparam int REG_W  = 64;
  localparam int ADDR_W = 6;
  localparam int IDX_W  = 3;

  localparam int SCREEN_WIDTH  = 1920;
  localparam int SCREEN_HEIGHT = 1080;

  localparam logic signed [CLIP_W-1:0] W_MIN = CLIP_W'(16777);

  typedef logic [N_REGS-1:0][REG_W-1:0] mat_regs_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } tag_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic ok;
    logic neg_x;
    logic neg_y;
    logic sat_x;
    logic sat_y;
  } side_t;

  // Entry m[row][col]; even columns sit in the upper half of a pair.
  function automatic logic signed [MAT_W-1:0] mat_entry(mat_regs_t regs, logic [1:0] row,
                                                        logic [1:0] col);
    logic [REG_W-1:0] pair;
    pair = regs[{row, col[1]}];
    return col[0] ? $signed(pair[MAT_W-1:0]) : $signed(pair[REG_W-1:MAT_W]);
  endfunction

endpackage
`default_nettype wire

@@ src/project_box_to_screen_rect_unit.sv @@
// Top level: axis-aligned box to projected screen rectangle.
//
//  channel   dir  handshake                  word
//  s_        in   s_tvalid / s_tready        one box (origin, min and max offsets)
//  m_        out  m_tvalid / m_tready        one screen rectangle, valid flag in tuser
//  apb       in   psel / penable / pready    matrix pair registers, 64 bits each
//
// The sequencer issues the eight corners of a box one per cycle, while no result stalls,
// into a shared transform, a 36-stage two-lane divider and the pixel stages; a new box
// is taken on the cycle its predecessor issues its last corner.
// Reset is synchronous and clears valid bits and the matrix (all boxes invalid).
// A result waiting on m_tready holds every stage, nothing is dropped or repeated.
`default_nettype none
module project_box_to_screen_rect_unit #(
  parameter int SCREEN_WIDTH  = pbsr_pkg::SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = pbsr_pkg::SCREEN_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pbsr_pkg::ADDR_W-1:0]      paddr,
  input  logic [pbsr_pkg::REG_W-1:0]       pwdata,
  output logic [pbsr_pkg::REG_W-1:0]       prdata,
  output logic                             pready,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // origin_x, origin_y, origin_z, min_off_x, min_off_y, min_off_z,
  // max_off_x, max_off_y, max_off_z (24 bits each)
  input  logic [9*pbsr_pkg::COORD_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // rect_left, rect_top, rect_right, rect_bottom (16 bits each)
  output logic [4*pbsr_pkg::PIX_W-1:0]     m_tdata,
  // box_valid
  output logic [0:0]                       m_tuser
);
  import pbsr_pkg::*;

  mat_regs_t                  regs;
  logic                       adv;
  logic [2:0][CORNER_W-1:0]   corner;
  tag_t                       tag;
  logic [NORM_W-1:0]          den, rem_x, rem_y;
  logic [DIV_BITS-1:0]        nq_x, nq_y, quo_x, quo_y;
  side_t                      side_x, side_d;

  pbsr_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .regs
  );

  pbsr_corner u_corner (
    .clk, .rst, .adv, .s_tvalid, .s_tready, .s_tdata, .corner, .tag
  );

  pbsr_xform u_xform (
    .clk, .rst, .adv, .regs, .corner, .tag,
    .den, .rem_x, .rem_y, .nq_x, .nq_y, .side(side_x)
  );

  pbsr_div u_div (
    .clk, .rst, .adv, .den, .rem_x, .rem_y, .nq_x, .nq_y,
    .side_i(side_x), .quo_x, .quo_y, .side_o(side_d)
  );

  pbsr_pixel #(
    .SCREEN_WIDTH(SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_pixel (
    .clk, .rst, .adv, .quo_x, .quo_y, .side_i(side_d),
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("box taken while result stalled");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
    else $error("invalid box with nonzero rectangle");

  a_rect_ordered: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |->
      ($signed(m_tdata[15:0]) <= $signed(m_tdata[47:32]) &&
       $signed(m_tdata[31:16]) <= $signed(m_tdata[63:48])))
    else $error("rectangle edges out of order");

endmodule
`default_nettype wire

@@ src/pbsr_cfg.sv @@
// APB register file holding the eight matrix pair registers.
`default_nettype none
module pbsr_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pbsr_pkg::ADDR_W-1:0] paddr,
  input  logic [pbsr_pkg::REG_W-1:0]  pwdata,
  output logic [pbsr_pkg::REG_W-1:0]  prdata,
  output logic                       pready,
  output pbsr_pkg::mat_regs_t        regs
);
  import pbsr_pkg::*;

  logic [IDX_W-1:0] idx;

  assign idx    = paddr[ADDR_W-1:ADDR_W-IDX_W];
  assign pready = 1'b1;
  assign prdata = regs[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (psel && penable && pwrite) begin
      regs[idx] <= pwdata;
    end
  end

endmodule
`default_nettype wire

@@ src/pbsr_corner.sv @@
// Box capture and corner sequencer: one world corner per cycle while the pipe advances.
`default_nettype none
module pbsr_corner (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 adv,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [9*pbsr_pkg::COORD_W-1:0]       s_tdata,
  output logic [2:0][pbsr_pkg::CORNER_W-1:0]   corner,
  output pbsr_pkg::tag_t                       tag
);
  import pbsr_pkg::*;

  logic signed [CORNER_W-1:0] lo [3];
  logic signed [CORNER_W-1:0] hi [3];
  logic       busy;
  logic [2:0] cnt;
  logic       accept;

  assign s_tready = adv && (!busy || cnt == 3'd7);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= '0;
      tag.valid <= 1'b0;
    end else if (adv) begin
      tag.valid <= busy;
      tag.first <= (cnt == 3'd0);
      tag.last  <= (cnt == 3'd7);
      for (int i = 0; i < 3; i++) begin
        corner[i] <= cnt[i] ? hi[i] : lo[i];
      end
      if (accept) begin
        busy <= 1'b1;
        cnt  <= '0;
        for (int i = 0; i < 3; i++) begin
          lo[i] <= CORNER_W'($signed(s_tdata[i*COORD_W +: COORD_W]))
                 + CORNER_W'($signed(s_tdata[(3+i)*COORD_W +: COORD_W]));
          hi[i] <= CORNER_W'($signed(s_tdata[i*COORD_W +: COORD_W]))
                 + CORNER_W'($signed(s_tdata[(6+i)*COORD_W +: COORD_W]));
        end
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd7) busy <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/pbsr_xform.sv @@
// Matrix transform, form selection and divider setup (five stages).
`default_nettype none
module pbsr_xform (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  pbsr_pkg::mat_regs_t                 regs,
  input  logic [2:0][pbsr_pkg::CORNER_W-1:0]  corner,
  input  pbsr_pkg::tag_t                      tag,
  output logic [pbsr_pkg::NORM_W-1:0]         den,
  output logic [pbsr_pkg::NORM_W-1:0]         rem_x,
  output logic [pbsr_pkg::NORM_W-1:0]         rem_y,
  output logic [pbsr_pkg::DIV_BITS-1:0]       nq_x,
  output logic [pbsr_pkg::DIV_BITS-1:0]       nq_y,
  output pbsr_pkg::side_t                     side
);
  import pbsr_pkg::*;

  // stage 1: products
  logic signed [PROD_W-1:0] prod0 [3][3];
  logic signed [PROD_W-1:0] prod1 [3][3];
  tag_t                     tag1;
  // stage 2: clip sums, both forms
  logic signed [CLIP_W-1:0] clip0 [3];
  logic signed [CLIP_W-1:0] clip1 [3];
  tag_t                     tag2;
  // stage 3: selected form, magnitudes, shift amount
  logic [CLIP_W-1:0]  ax3, ay3, d3;
  logic [SHIFT_W-1:0] sh3;
  side_t              side3;
  // stage 4: normalized
  logic [CLIP_W-1:0]  ax4, ay4;
  logic [NORM_W-1:0]  d4;
  side_t              side4;

  logic               use0, use1;
  logic signed [CLIP_W-1:0] sel_x, sel_y, sel_w;
  logic [SHIFT_W-1:0] sh_calc;
  logic [SAT_SHIFT+NORM_W-1:0] d_limit;

  always_comb begin
    use0  = clip0[2] >= W_MIN;
    use1  = clip1[2] >= W_MIN;
    sel_x = use0 ? clip0[0] : clip1[0];
    sel_y = use0 ? clip0[1] : clip1[1];
    sel_w = use0 ? clip0[2] : clip1[2];
    sh_calc = '0;
    for (int i = NORM_W; i < CLIP_W; i++) begin
      if (sel_w[i]) sh_calc = SHIFT_W'(i - NORM_W + 1);
    end
    d_limit = {d4, {SAT_SHIFT{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.valid  <= 1'b0;
      tag2.valid  <= 1'b0;
      side3.valid <= 1'b0;
      side4.valid <= 1'b0;
      side.valid  <= 1'b0;
    end else if (adv) begin
      tag1 <= tag;
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          prod0[k][i] <= $signed(corner[i])
                       * mat_entry(regs, (k == 2) ? 2'd3 : 2'(k), 2'(i));
          prod1[k][i] <= $signed(corner[i])
                       * mat_entry(regs, 2'(i), (k == 2) ? 2'd3 : 2'(k));
        end
      end

      tag2 <= tag1;
      for (int k = 0; k < 3; k++) begin
        clip0[k] <= CLIP_W'(prod0[k][0]) + CLIP_W'(prod0[k][1]) + CLIP_W'(prod0[k][2])
                  + CLIP_W'($signed({mat_entry(regs, (k == 2) ? 2'd3 : 2'(k), 2'd3),
                                     8'h00}));
        clip1[k] <= CLIP_W'(prod1[k][0]) + CLIP_W'(prod1[k][1]) + CLIP_W'(prod1[k][2])
                  + CLIP_W'($signed({mat_entry(regs, 2'd3, (k == 2) ? 2'd3 : 2'(k)),
                                     8'h00}));
      end

      side3.valid <= tag2.valid;
      side3.first <= tag2.first;
      side3.last  <= tag2.last;
      side3.ok    <= use0 || use1;
      side3.neg_x <= sel_x < 0;
      side3.neg_y <= sel_y < 0;
      side3.sat_x <= 1'b0;
      side3.sat_y <= 1'b0;
      ax3 <= (sel_x < 0) ? $unsigned(-sel_x) : $unsigned(sel_x);
      ay3 <= (sel_y < 0) ? $unsigned(-sel_y) : $unsigned(sel_y);
      d3  <= $unsigned(sel_w);
      sh3 <= sh_calc;

      // shift denominator and numerators together
      side4 <= side3;
      ax4   <= ax3 >> sh3;
      ay4   <= ay3 >> sh3;
      d4    <= NORM_W'(d3 >> sh3);

      side.valid <= side4.valid;
      side.first <= side4.first;
      side.last  <= side4.last;
      side.ok    <= side4.ok;
      side.neg_x <= side4.neg_x;
      side.neg_y <= side4.neg_y;
      side.sat_x <= (SAT_SHIFT+NORM_W)'(ax4) >= d_limit;
      side.sat_y <= (SAT_SHIFT+NORM_W)'(ay4) >= d_limit;
      den   <= d4;
      rem_x <= NORM_W'(ax4[CLIP_W-1:SAT_SHIFT]);
      rem_y <= NORM_W'(ay4[CLIP_W-1:SAT_SHIFT]);
      nq_x  <= {ax4[SAT_SHIFT-1:0], {FRAC_W{1'b0}}};
      nq_y  <= {ay4[SAT_SHIFT-1:0], {FRAC_W{1'b0}}};
    end
  end

endmodule
`default_nettype wire

@@ src/pbsr_div.sv @@
// Two-lane pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module pbsr_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  logic [pbsr_pkg::NORM_W-1:0]    den,
  input  logic [pbsr_pkg::NORM_W-1:0]    rem_x,
  input  logic [pbsr_pkg::NORM_W-1:0]    rem_y,
  input  logic [pbsr_pkg::DIV_BITS-1:0]  nq_x,
  input  logic [pbsr_pkg::DIV_BITS-1:0]  nq_y,
  input  pbsr_pkg::side_t                side_i,
  output logic [pbsr_pkg::DIV_BITS-1:0]  quo_x,
  output logic [pbsr_pkg::DIV_BITS-1:0]  quo_y,
  output pbsr_pkg::side_t                side_o
);
  import pbsr_pkg::*;

  // per stage: numerator bits still to shift in at the top, quotient bits at the bottom
  logic [NORM_W-1:0]   rin_x [DIV_BITS];
  logic [NORM_W-1:0]   rin_y [DIV_BITS];
  logic [NORM_W-1:0]   din   [DIV_BITS];
  logic [DIV_BITS-1:0] qin_x [DIV_BITS];
  logic [DIV_BITS-1:0] qin_y [DIV_BITS];
  side_t               sin   [DIV_BITS];

  logic [NORM_W-1:0]   rq_x  [DIV_BITS-1];
  logic [NORM_W-1:0]   rq_y  [DIV_BITS-1];
  logic [NORM_W-1:0]   dq    [DIV_BITS-1];
  logic [DIV_BITS-1:0] qq_x  [DIV_BITS];
  logic [DIV_BITS-1:0] qq_y  [DIV_BITS];
  side_t               sq    [DIV_BITS];

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_stage
    logic [NORM_W:0]   sh_x, sh_y, dd;
    logic              ge_x, ge_y;

    if (k == 0) begin : g_head
      assign rin_x[k] = rem_x;
      assign rin_y[k] = rem_y;
      assign din[k]   = den;
      assign qin_x[k] = nq_x;
      assign qin_y[k] = nq_y;
      assign sin[k]   = side_i;
    end else begin : g_body
      assign rin_x[k] = rq_x[k-1];
      assign rin_y[k] = rq_y[k-1];
      assign din[k]   = dq[k-1];
      assign qin_x[k] = qq_x[k-1];
      assign qin_y[k] = qq_y[k-1];
      assign sin[k]   = sq[k-1];
    end

    assign dd   = {1'b0, din[k]};
    assign sh_x = {rin_x[k], qin_x[k][DIV_BITS-1]};
    assign sh_y = {rin_y[k], qin_y[k][DIV_BITS-1]};
    assign ge_x = sh_x >= dd;
    assign ge_y = sh_y >= dd;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq[k].valid <= 1'b0;
      end else if (adv) begin
        sq[k] <= sin[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        qq_x[k] <= {qin_x[k][DIV_BITS-2:0], ge_x};
        qq_y[k] <= {qin_y[k][DIV_BITS-2:0], ge_y};
      end
    end

    if (k < DIV_BITS - 1) begin : g_carry
      logic [NORM_W-1:0] rn_x, rn_y;

      assign rn_x = ge_x ? NORM_W'(sh_x - dd) : NORM_W'(sh_x);
      assign rn_y = ge_y ? NORM_W'(sh_y - dd) : NORM_W'(sh_y);

      always_ff @(posedge clk) begin
        if (adv) begin
          rq_x[k] <= rn_x;
          rq_y[k] <= rn_y;
          dq[k]   <= din[k];
        end
      end
    end
  end

  assign quo_x  = qq_x[DIV_BITS-1];
  assign quo_y  = qq_y[DIV_BITS-1];
  assign side_o = sq[DIV_BITS-1];

endmodule
`default_nettype wire

@@ src/pbsr_pixel.sv @@
// Pixel mapping, saturation, rectangle accumulation and result register.
`default_nettype none
module pbsr_pixel #(
  parameter int SCREEN_WIDTH  = pbsr_pkg::SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = pbsr_pkg::SCREEN_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst,
  output logic                           adv,
  input  logic [pbsr_pkg::DIV_BITS-1:0]  quo_x,
  input  logic [pbsr_pkg::DIV_BITS-1:0]  quo_y,
  input  pbsr_pkg::side_t                side_i,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [4*pbsr_pkg::PIX_W-1:0]   m_tdata,
  output logic [0:0]                     m_tuser
);
  import pbsr_pkg::*;

  localparam logic signed [DIM_W-1:0]  DIM_X    = DIM_W'(SCREEN_WIDTH);
  localparam logic signed [DIM_W-1:0]  DIM_Y    = DIM_W'(SCREEN_HEIGHT);
  localparam logic signed [TERM_W-1:0] ONE      = TERM_W'(1 << FRAC_W);
  localparam logic [RATIO_W-1:0]       T_SAT    = RATIO_W'(1) << DIV_BITS;
  localparam logic signed [PIX_PROD_W-1:0] HALF = PIX_PROD_W'(1 << FRAC_W);
  localparam logic signed [PIX_W-1:0]  PIX_MAX  = {1'b0, {(PIX_W-1){1'b1}}};
  localparam logic signed [PIX_W-1:0]  PIX_MIN  = {1'b1, {(PIX_W-1){1'b0}}};

  function automatic logic signed [PIX_W-1:0] to_pix(logic signed [PIX_PROD_W-1:0] p);
    logic signed [PIX_PROD_W-1:0] v;
    v = (p + HALF) >>> PIX_SHIFT;
    if (v > PIX_PROD_W'(PIX_MAX)) return PIX_MAX;
    if (v < PIX_PROD_W'(PIX_MIN)) return PIX_MIN;
    return v[PIX_W-1:0];
  endfunction

  logic signed [TERM_W-1:0]     term_x, term_y;
  logic signed [PIX_PROD_W-1:0] prod_x, prod_y;
  logic signed [PIX_W-1:0]      sx, sy;
  side_t                        side1, side2, side3;

  logic signed [PIX_W-1:0] acc_l, acc_t, acc_r, acc_b;
  logic                    acc_ok;
  logic signed [PIX_W-1:0] base_l, base_t, base_r, base_b;
  logic signed [PIX_W-1:0] new_l, new_t, new_r, new_b;
  logic                    new_ok;
  logic signed [TERM_W-1:0] tx_s, ty_s;

  logic                    res_valid;
  logic                    res_ok;
  logic [PIX_W-1:0]        res_l, res_t, res_r, res_b;

  // hold the whole pipe while a finished result waits
  assign adv = !res_valid || m_tready;

  always_comb begin
    tx_s = $signed({2'b00, side_i.sat_x ? T_SAT : {1'b0, quo_x}});
    ty_s = $signed({2'b00, side_i.sat_y ? T_SAT : {1'b0, quo_y}});

    base_l = side3.first ? PIX_MAX : acc_l;
    base_t = side3.first ? PIX_MAX : acc_t;
    base_r = side3.first ? PIX_MIN : acc_r;
    base_b = side3.first ? PIX_MIN : acc_b;
    new_l  = (sx < base_l) ? sx : base_l;
    new_t  = (sy < base_t) ? sy : base_t;
    new_r  = (sx > base_r) ? sx : base_r;
    new_b  = (sy > base_b) ? sy : base_b;
    new_ok = (side3.first || acc_ok) && side3.ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side1.valid <= 1'b0;
      side2.valid <= 1'b0;
      side3.valid <= 1'b0;
      res_valid   <= 1'b0;
    end else if (adv) begin
      res_valid <= side3.valid && side3.last;

      side1  <= side_i;
      term_x <= ONE + (side_i.neg_x ? -tx_s : tx_s);
      term_y <= ONE + (side_i.neg_y ? ty_s : -ty_s);

      side2  <= side1;
      prod_x <= term_x * DIM_X;
      prod_y <= term_y * DIM_Y;

      side3  <= side2;
      sx     <= to_pix(prod_x);
      sy     <= to_pix(prod_y);

      if (side3.valid) begin
        acc_l  <= new_l;
        acc_t  <= new_t;
        acc_r  <= new_r;
        acc_b  <= new_b;
        acc_ok <= new_ok;
        if (side3.last) begin
          res_ok <= new_ok;
          res_l  <= new_ok ? new_l : '0;
          res_t  <= new_ok ? new_t : '0;
          res_r  <= new_ok ? new_r : '0;
          res_b  <= new_ok ? new_b : '0;
        end
      end
    end
  end

  assign m_tvalid   = res_valid;
  assign m_tdata    = {res_b, res_r, res_t, res_l};
  assign m_tuser[0] = res_ok;

endmodule
`default_nettype wire
